### design/lwbc_pkg.sv
// shared widths, result kinds and result record for the block cache controller
package lwbc_pkg;

  localparam int BLOCK_W     = 14;
  localparam int OFFSET_W    = 9;
  localparam int SLOT_W      = 3;
  localparam int LEFT_W      = 10;
  localparam int KIND_W      = 2;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 32;

  localparam logic [KIND_W-1:0] KIND_WRITEBACK = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DONE      = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RANGE     = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [SLOT_W-1:0]  slot;
    logic [BLOCK_W-1:0] blk;
    logic               hit;
    logic               fill;
    logic [LEFT_W-1:0]  left;
    logic               last;
  } res_t;

endpackage

### design/lwbc_ram.sv
// generic simple dual-port ram with registered read
module lwbc_ram #(
  parameter int WIDTH = 14,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

### design/lru_writeback_block_cache.sv
// fully associative lru write-back block cache controller, top level
// a miss whose victim is dirty first emits a writeback beat for each dirty slot, oldest first
// flow: one access at a time, input ready only while the sequencer is idle, so a new access
//   is taken only after the final result beat of the previous one has been registered
// reset: synchronous active-low rst_n; slots hold blocks SLOTS-1 down to 0 through
//   per-slot valid bits, all clean, slot i at recency rank i, no highest block seen
module lru_writeback_block_cache #(
  parameter int SLOTS       = 8,
  parameter int BLOCK_LIMIT = 4096,
  parameter int BLOCK_BYTES = 512
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // block_number [13:0], byte_offset [22:14], zero pad [23]
  input  logic [lwbc_pkg::IN_TDATA_W-1:0]  in_tdata,
  // mark_dirty [0]
  input  logic                             in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // slot_index [2:0], slot_block [16:3], was_hit [17], fill_needed [18],
  // bytes_left [28:19], zero pad [31:29]
  output logic [lwbc_pkg::OUT_TDATA_W-1:0] out_tdata,
  // result_kind [1:0]
  output logic [lwbc_pkg::KIND_W-1:0]      out_tuser,
  output logic                             out_tlast
);

  import lwbc_pkg::*;

  localparam int SW  = $clog2(SLOTS);
  localparam int IW  = $clog2(SLOTS + 1);
  localparam int BBW = $clog2(BLOCK_BYTES + 1);
  localparam int LW  = (BBW > LEFT_W) ? BBW : LEFT_W;

  // sequencer states
  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_SCAN    = 3'd1;
  localparam logic [2:0] ST_HIT     = 3'd2;
  localparam logic [2:0] ST_WB_LOOK = 3'd3;
  localparam logic [2:0] ST_WB_EMIT = 3'd4;
  localparam logic [2:0] ST_FINAL   = 3'd5;
  localparam logic [2:0] ST_RANGE   = 3'd6;

  logic [2:0]         state_r, state_nxt;
  logic [BLOCK_W-1:0] blk_r, blk_nxt;
  logic               wr_r, wr_nxt;
  logic [LEFT_W-1:0]  left_r, left_nxt;
  logic [IW-1:0]      idx_r, idx_nxt;
  logic               cmp_vld_r, cmp_vld_nxt;
  logic [SW-1:0]      rd_slot_r, rd_slot_nxt;
  logic [SW-1:0]      sel_slot_r, sel_slot_nxt;
  logic [SW-1:0]      rcnt_r, rcnt_nxt;
  logic [SW-1:0]      rank_r [SLOTS];
  logic [SW-1:0]      rank_nxt [SLOTS];
  logic [SLOTS-1:0]   dirty_r, dirty_nxt;
  logic [SLOTS-1:0]   tvld_r, tvld_nxt;
  logic [BLOCK_W-1:0] hi_blk_r, hi_blk_nxt;
  logic               hi_vld_r, hi_vld_nxt;
  res_t               res_r, res_nxt;
  logic               out_vld_r, out_vld_nxt;

  // tag ram port signals
  logic               ram_we;
  logic [BLOCK_W-1:0] ram_q;
  logic               ram_re;
  logic [SW-1:0]      ram_raddr;

  logic [BLOCK_W-1:0] in_blk;
  logic [OFFSET_W-1:0] in_off;
  logic [15:0]        off_w;
  logic [LW-1:0]      off_m;
  logic [LW-1:0]      left_full;
  logic [BLOCK_W-1:0] tag_view;
  logic [SW-1:0]      vict_slot;
  logic [SW-1:0]      walk_slot;
  logic               out_free;
  logic               in_beat;
  logic               in_range;
  logic               commit;
  logic [SW-1:0]      old_rank;

  assign in_blk   = in_tdata[BLOCK_W-1:0];
  assign in_off   = in_tdata[BLOCK_W+OFFSET_W-1:BLOCK_W];
  assign in_tready = (state_r == ST_IDLE);
  assign in_beat  = in_tvalid && in_tready;
  assign out_free = !out_vld_r || out_tready;
  assign in_range = ({1'b0, in_blk} < (BLOCK_W + 1)'(BLOCK_LIMIT));

  // offset modulo block size: take off the largest of the first seven multiples that is not
  // above the offset; all seven multiples are compared side by side
  always_comb begin
    off_w = 16'(in_off);
    off_m = LW'(in_off);
    for (int k = 1; k < 8; k++) begin
      if (off_w >= 16'(k * BLOCK_BYTES)) begin
        off_m = LW'(off_w - 16'(k * BLOCK_BYTES));
      end
    end
    left_full = LW'(BLOCK_BYTES) - off_m;
  end

  // a slot never retagged still holds its power-up block
  assign tag_view = tvld_r[rd_slot_r] ? ram_q
                                      : (BLOCK_W'(SLOTS - 1) - BLOCK_W'(rd_slot_r));

  // rank to slot lookup: oldest slot and the slot at the walk rank
  always_comb begin
    vict_slot = '0;
    walk_slot = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (rank_r[i] == SW'(SLOTS - 1)) begin
        vict_slot = vict_slot | SW'(i);
      end
      if (rank_r[i] == rcnt_r) begin
        walk_slot = walk_slot | SW'(i);
      end
    end
  end

  assign old_rank = rank_r[sel_slot_r];

  always_comb begin
    state_nxt    = state_r;
    blk_nxt      = blk_r;
    wr_nxt       = wr_r;
    left_nxt     = left_r;
    idx_nxt      = idx_r;
    cmp_vld_nxt  = cmp_vld_r;
    rd_slot_nxt  = rd_slot_r;
    sel_slot_nxt = sel_slot_r;
    rcnt_nxt     = rcnt_r;
    dirty_nxt    = dirty_r;
    tvld_nxt     = tvld_r;
    hi_blk_nxt   = hi_blk_r;
    hi_vld_nxt   = hi_vld_r;
    res_nxt      = res_r;
    out_vld_nxt  = out_vld_r && !out_tready;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_raddr    = rd_slot_r;
    commit       = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      rank_nxt[i] = rank_r[i];
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_beat) begin
          blk_nxt     = in_blk;
          wr_nxt      = in_tuser;
          left_nxt    = left_full[LEFT_W-1:0];
          idx_nxt     = '0;
          cmp_vld_nxt = 1'b0;
          state_nxt   = in_range ? ST_SCAN : ST_RANGE;
        end
      end
      ST_SCAN: begin
        // compare the slot read last cycle while reading the next one
        if (cmp_vld_r && (tag_view == blk_r)) begin
          sel_slot_nxt = rd_slot_r;
          cmp_vld_nxt  = 1'b0;
          state_nxt    = ST_HIT;
        end else if (idx_r == IW'(SLOTS)) begin
          cmp_vld_nxt  = 1'b0;
          sel_slot_nxt = vict_slot;
          rcnt_nxt     = SW'(SLOTS - 1);
          state_nxt    = dirty_r[vict_slot] ? ST_WB_LOOK : ST_FINAL;
        end else begin
          ram_re      = 1'b1;
          ram_raddr   = idx_r[SW-1:0];
          rd_slot_nxt = idx_r[SW-1:0];
          cmp_vld_nxt = 1'b1;
          idx_nxt     = idx_r + IW'(1);
        end
      end
      ST_WB_LOOK: begin
        // walk ranks oldest first, fetch the tag of each dirty slot
        if (dirty_r[walk_slot]) begin
          ram_re      = 1'b1;
          ram_raddr   = walk_slot;
          rd_slot_nxt = walk_slot;
          state_nxt   = ST_WB_EMIT;
        end else if (rcnt_r == '0) begin
          state_nxt = ST_FINAL;
        end else begin
          rcnt_nxt = rcnt_r - SW'(1);
        end
      end
      ST_WB_EMIT: begin
        if (out_free) begin
          res_nxt.kind = KIND_WRITEBACK;
          res_nxt.slot = SLOT_W'(rd_slot_r);
          res_nxt.blk  = tag_view;
          res_nxt.hit  = 1'b0;
          res_nxt.fill = 1'b0;
          res_nxt.left = '0;
          res_nxt.last = 1'b0;
          out_vld_nxt  = 1'b1;
          dirty_nxt[rd_slot_r] = 1'b0;
          if (rcnt_r == '0) begin
            state_nxt = ST_FINAL;
          end else begin
            rcnt_nxt  = rcnt_r - SW'(1);
            state_nxt = ST_WB_LOOK;
          end
        end
      end
      ST_FINAL: begin
        // retag the victim and report the miss
        if (out_free) begin
          commit       = 1'b1;
          ram_we       = 1'b1;
          tvld_nxt[sel_slot_r]  = 1'b1;
          dirty_nxt[sel_slot_r] = wr_r;
          res_nxt.kind = KIND_DONE;
          res_nxt.slot = SLOT_W'(sel_slot_r);
          res_nxt.blk  = blk_r;
          res_nxt.hit  = 1'b0;
          res_nxt.left = left_r;
          res_nxt.last = 1'b1;
          if (hi_vld_r && (blk_r <= hi_blk_r)) begin
            res_nxt.fill = 1'b1;
          end else begin
            res_nxt.fill = 1'b0;
            hi_blk_nxt   = blk_r;
            hi_vld_nxt   = 1'b1;
          end
          out_vld_nxt  = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      ST_HIT: begin
        if (out_free) begin
          commit = 1'b1;
          dirty_nxt[sel_slot_r] = dirty_r[sel_slot_r] | wr_r;
          if (!hi_vld_r || (blk_r > hi_blk_r)) begin
            hi_blk_nxt = blk_r;
            hi_vld_nxt = 1'b1;
          end
          res_nxt.kind = KIND_DONE;
          res_nxt.slot = SLOT_W'(sel_slot_r);
          res_nxt.blk  = blk_r;
          res_nxt.hit  = 1'b1;
          res_nxt.fill = 1'b0;
          res_nxt.left = left_r;
          res_nxt.last = 1'b1;
          out_vld_nxt  = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      ST_RANGE: begin
        if (out_free) begin
          res_nxt.kind = KIND_RANGE;
          res_nxt.slot = '0;
          res_nxt.blk  = '0;
          res_nxt.hit  = 1'b0;
          res_nxt.fill = 1'b0;
          res_nxt.left = '0;
          res_nxt.last = 1'b1;
          out_vld_nxt  = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // move the served slot to most recently used
    if (commit) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (rank_r[i] < old_rank) begin
          rank_nxt[i] = rank_r[i] + SW'(1);
        end
      end
      rank_nxt[sel_slot_r] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      cmp_vld_r <= 1'b0;
      dirty_r   <= '0;
      tvld_r    <= '0;
      hi_blk_r  <= '0;
      hi_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        rank_r[i] <= SW'(i);
      end
    end else begin
      state_r   <= state_nxt;
      cmp_vld_r <= cmp_vld_nxt;
      dirty_r   <= dirty_nxt;
      tvld_r    <= tvld_nxt;
      hi_blk_r  <= hi_blk_nxt;
      hi_vld_r  <= hi_vld_nxt;
      out_vld_r <= out_vld_nxt;
      for (int i = 0; i < SLOTS; i++) begin
        rank_r[i] <= rank_nxt[i];
      end
    end
  end

  // payload and scan bookkeeping, no reset needed
  always_ff @(posedge clk) begin
    blk_r      <= blk_nxt;
    wr_r       <= wr_nxt;
    left_r     <= left_nxt;
    idx_r      <= idx_nxt;
    rd_slot_r  <= rd_slot_nxt;
    sel_slot_r <= sel_slot_nxt;
    rcnt_r     <= rcnt_nxt;
    res_r      <= res_nxt;
  end

  // tag store, one slot read per cycle
  lwbc_ram #(
    .WIDTH (BLOCK_W),
    .DEPTH (SLOTS)
  ) u_tag_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (sel_slot_r),
    .wr_data (blk_r),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_q)
  );

  assign out_tvalid = out_vld_r;
  assign out_tuser  = res_r.kind;
  assign out_tlast  = res_r.last;
  assign out_tdata  = {3'b000, res_r.left, res_r.fill, res_r.hit, res_r.blk, res_r.slot};

endmodule
